[hdl/dqi_pkg.sv]
// ----------------------------------------------------------------------------
// dqi_pkg
// Shared constants and the cosine weight table of the dequantizing 8x8 IDCT.
// ----------------------------------------------------------------------------
package dqi_pkg;

	localparam int COEF_WIDTH_DEF = 16;
	localparam int COS_FRAC_DEF   = 14;
	localparam int TAB_BITS       = 24;
	localparam int ROW_WIDTH      = 22;
	localparam int IN_COEF_W      = 16;
	localparam int QUANT_W        = 16;
	localparam int SAMPLE_W       = 8;
	localparam int POS_W          = 6;
	localparam int NPOS           = 64;
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(NPOS - 1);

	localparam logic [24:0] COS_MAG [0:8] = '{
		25'd16777216, 25'd16454846, 25'd15500126, 25'd13949745, 25'd11863283,
		25'd9320922, 25'd6420363, 25'd3273072, 25'd0
	};

	// c(u)*cos((2i+1)u*pi/16), rounded half away from zero to frac fraction bits
	function automatic logic signed [31:0] weight(input logic [2:0] i, input logic [2:0] u,
			input int frac);
		logic [24:0] m;
		logic        neg;
		logic [4:0]  k;
		logic [25:0] r;
		int          d;
		d   = TAB_BITS - frac;
		k   = 5'(8'({i, 1'b1}) * 8'(u));
		neg = 1'b0;
		if (u == 3'd0) begin
			m = COS_MAG[4];
		end else if (k <= 5'd8) begin
			m = COS_MAG[k[3:0]];
		end else if (k <= 5'd16) begin
			m   = COS_MAG[4'(5'd16 - k)];
			neg = 1'b1;
		end else if (k <= 5'd24) begin
			m   = COS_MAG[4'(k - 5'd16)];
			neg = 1'b1;
		end else begin
			m = COS_MAG[4'(6'd32 - {1'b0, k})];
		end
		r = ({1'b0, m} + (26'd1 << (d - 1))) >> d;
		weight = neg ? -$signed({6'b0, r}) : $signed({6'b0, r});
	endfunction

endpackage

[hdl/dqi_if.sv]
// ----------------------------------------------------------------------------
// dqi_if
// Valid/ready channels: input words and output sample words.
// ----------------------------------------------------------------------------
interface dqi_in_if;
	logic                                valid;
	logic                                ready;
	logic                                mode;
	logic [dqi_pkg::POS_W-1:0]           position;
	logic signed [dqi_pkg::IN_COEF_W-1:0] coefficient;
	logic [dqi_pkg::QUANT_W-1:0]         quant_value;

	modport source(output valid, mode, position, coefficient, quant_value, input ready);
	modport sink(input valid, mode, position, coefficient, quant_value, output ready);
endinterface

interface dqi_out_if;
	logic                         valid;
	logic                         ready;
	logic [dqi_pkg::SAMPLE_W-1:0] sample;
	logic [dqi_pkg::POS_W-1:0]    pixel_index;
	logic                         last;

	modport source(output valid, sample, pixel_index, last, input ready);
	modport sink(input valid, sample, pixel_index, last, output ready);
endinterface

[hdl/dequant_idct_8x8.sv]
// ----------------------------------------------------------------------------
// dequant_idct_8x8
// Dequantizing 8x8 inverse DCT producing level-shifted 8-bit samples.
// ----------------------------------------------------------------------------
// in_ch takes one word per handshake: mode 0 writes a quantizer word at
// position, mode 1 supplies a coefficient that is multiplied by the stored
// quantizer word, saturated and written to the coefficient RAM. A mode 0
// word keeps in_ch ready, a mode 1 word stalls it until its RAM write.
// The coefficient at position 63 closes the block and starts the transform:
// 128 outputs (64 row, 64 column) are computed in turn on the single shared
// multiply-accumulate, fed by the one-read-per-cycle RAM port. in_ch is not
// ready during the transform.
// out_ch then delivers 64 sample words in row-major order, last on the 64th.
// A stalled receiver holds the output register and pauses the column pass.
// Reset makes the quantizer table read as zero; coefficients are expected
// at every position before each block closes.
// ----------------------------------------------------------------------------
module dequant_idct_8x8 #(
	parameter int COEF_WIDTH    = dqi_pkg::COEF_WIDTH_DEF,
	parameter int COS_FRAC_BITS = dqi_pkg::COS_FRAC_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	dqi_in_if.sink    in_ch,
	dqi_out_if.source out_ch
);
	import dqi_pkg::*;

	logic                  coef_we, coef_re, start, busy;
	logic [POS_W-1:0]      coef_waddr, coef_raddr;
	logic [COEF_WIDTH-1:0] coef_wdata, coef_rdata;

	dqi_dequant #(.COEF_WIDTH(COEF_WIDTH)) u_dequant (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.engine_busy (busy),
		.coef_we     (coef_we),
		.coef_waddr  (coef_waddr),
		.coef_wdata  (coef_wdata),
		.start       (start)
	);

	dqi_ram #(.WIDTH(COEF_WIDTH), .DEPTH(NPOS)) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (coef_waddr),
		.wdata (coef_wdata),
		.re    (coef_re),
		.raddr (coef_raddr),
		.rdata (coef_rdata)
	);

	dqi_idct #(.COEF_WIDTH(COEF_WIDTH), .COS_FRAC_BITS(COS_FRAC_BITS)) u_idct (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.coef_re    (coef_re),
		.coef_raddr (coef_raddr),
		.coef_rdata (coef_rdata),
		.out_ch     (out_ch)
	);

endmodule

[hdl/dqi_ram.sv]
// ----------------------------------------------------------------------------
// dqi_ram
// Generic single-clock RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module dqi_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hdl/dqi_dequant.sv]
// ----------------------------------------------------------------------------
// dqi_dequant
// Input side: quantizer table, coefficient dequantize and saturate.
// ----------------------------------------------------------------------------
module dqi_dequant #(
	parameter int COEF_WIDTH = dqi_pkg::COEF_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	dqi_in_if.sink                      in_ch,
	input  logic                        engine_busy,
	output logic                        coef_we,
	output logic [dqi_pkg::POS_W-1:0]   coef_waddr,
	output logic [COEF_WIDTH-1:0]       coef_wdata,
	output logic                        start
);
	import dqi_pkg::*;

	localparam int PW = IN_COEF_W + QUANT_W + 1;
	localparam logic signed [PW-1:0] SAT_HI = PW'((64'sd1 <<< (COEF_WIDTH - 1)) - 64'sd1);
	localparam logic signed [PW-1:0] SAT_LO = -SAT_HI - PW'(1);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_READ  = 3'b010,
		ST_WRITE = 3'b100
	} dq_state_t;

	dq_state_t                   state_q;
	logic [NPOS-1:0]             qvalid_q;
	logic                        qv_s1;
	logic signed [IN_COEF_W-1:0] coef_s1;
	logic [POS_W-1:0]            pos_s1;
	logic signed [PW-1:0]        prod_s2;
	logic [QUANT_W-1:0]          q_rdata;
	logic                        accept;

	assign in_ch.ready = (state_q == ST_IDLE) && !engine_busy;
	assign accept      = in_ch.valid && in_ch.ready;

	dqi_ram #(.WIDTH(QUANT_W), .DEPTH(NPOS)) u_quant_ram (
		.clk   (clk),
		.we    (accept && !in_ch.mode),
		.waddr (in_ch.position),
		.wdata (in_ch.quant_value),
		.re    (accept && in_ch.mode),
		.raddr (in_ch.position),
		.rdata (q_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			qvalid_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && !in_ch.mode) begin
						qvalid_q[in_ch.position] <= 1'b1;
					end
					if (accept && in_ch.mode) begin
						state_q <= ST_READ;
					end
				end
				ST_READ:  state_q <= ST_WRITE;
				ST_WRITE: state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			coef_s1 <= in_ch.coefficient;
			pos_s1  <= in_ch.position;
			qv_s1   <= qvalid_q[in_ch.position];
		end
		if (state_q == ST_READ) begin
			prod_s2 <= PW'(coef_s1) * $signed({1'b0, (qv_s1 ? q_rdata : QUANT_W'(0))});
		end
	end

	always_comb begin
		if (prod_s2 > SAT_HI) begin
			coef_wdata = COEF_WIDTH'(SAT_HI);
		end else if (prod_s2 < SAT_LO) begin
			coef_wdata = COEF_WIDTH'(SAT_LO);
		end else begin
			coef_wdata = COEF_WIDTH'(prod_s2);
		end
	end

	assign coef_we    = (state_q == ST_WRITE);
	assign coef_waddr = pos_s1;
	assign start      = (state_q == ST_WRITE) && (pos_s1 == LAST_POS);

endmodule

[hdl/dqi_idct.sv]
// ----------------------------------------------------------------------------
// dqi_idct
// Separable 8x8 IDCT on one shared multiply-accumulate, row pass to RAM,
// column pass to the output register.
// ----------------------------------------------------------------------------
module dqi_idct #(
	parameter int COEF_WIDTH    = dqi_pkg::COEF_WIDTH_DEF,
	parameter int COS_FRAC_BITS = dqi_pkg::COS_FRAC_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	output logic                      coef_re,
	output logic [dqi_pkg::POS_W-1:0] coef_raddr,
	input  logic [COEF_WIDTH-1:0]     coef_rdata,
	dqi_out_if.source                 out_ch
);
	import dqi_pkg::*;

	localparam int OPW = ROW_WIDTH;
	localparam int WW  = COS_FRAC_BITS + 2;
	localparam int PW  = OPW + WW;
	localparam int AW  = PW + 3;
	localparam int SR  = COS_FRAC_BITS - 3;
	localparam int SC  = COS_FRAC_BITS + 5;
	localparam logic signed [AW-1:0] LEVEL   = AW'(64'sd128 <<< SC);
	localparam logic [AW-1:0]        HALF_R  = AW'(64'd1 << (SR - 1));
	localparam logic [AW-1:0]        HALF_C  = AW'(64'd1 << (SC - 1));
	localparam logic [AW-1:0]        ROW_MAX = AW'((64'd1 << (ROW_WIDTH - 1)) - 64'd1);
	localparam logic [AW-1:0]        ROW_MIN = AW'(64'd1 << (ROW_WIDTH - 1));
	localparam logic [AW-1:0]        PIX_MAX = AW'(255);

	typedef enum logic [4:0] {
		E_IDLE  = 5'b00001,
		E_RUN   = 5'b00010,
		E_DRAIN = 5'b00100,
		E_FIN   = 5'b01000,
		E_DONE  = 5'b10000
	} eng_state_t;

	eng_state_t              state_q;
	logic                    col_q;
	logic [2:0]              y_q, x_q, k_q;
	logic                    rd_s1, mul_s2;
	logic signed [WW-1:0]    w_s1;
	logic signed [PW-1:0]    prod_s2;
	logic signed [AW-1:0]    acc_q;
	logic [AW-1:0]           mag_q;
	logic                    neg_q;
	logic [OPW-1:0]          row_rdata;
	logic signed [OPW-1:0]   operand;
	logic signed [AW-1:0]    fin_val;
	logic [AW-1:0]           r_row, r_col;
	logic [OPW-1:0]          row_val;
	logic [SAMPLE_W-1:0]     pix_val;
	logic                    out_free, issue, done_go, last_elem;
	logic                    out_valid_q, last_q;
	logic [SAMPLE_W-1:0]     sample_q;
	logic [POS_W-1:0]        index_q;

	assign busy       = (state_q != E_IDLE);
	assign issue      = (state_q == E_RUN);
	assign out_free   = !out_valid_q || out_ch.ready;
	assign done_go    = (state_q == E_DONE) && (!col_q || out_free);
	assign last_elem  = (y_q == 3'd7) && (x_q == 3'd7);
	assign coef_re    = issue && !col_q;
	assign coef_raddr = {y_q, k_q};

	dqi_ram #(.WIDTH(OPW), .DEPTH(NPOS)) u_row_ram (
		.clk   (clk),
		.we    (done_go && !col_q),
		.waddr ({y_q, x_q}),
		.wdata (row_val),
		.re    (issue && col_q),
		.raddr ({k_q, x_q}),
		.rdata (row_rdata)
	);

	assign operand = col_q ? $signed(row_rdata)
		: $signed({{(OPW - COEF_WIDTH){coef_rdata[COEF_WIDTH-1]}}, coef_rdata});
	assign fin_val = col_q ? (acc_q + LEVEL) : acc_q;
	assign r_row   = (mag_q + HALF_R) >> SR;
	assign r_col   = (mag_q + HALF_C) >> SC;

	always_comb begin
		if (!neg_q) begin
			row_val = (r_row > ROW_MAX) ? OPW'(ROW_MAX) : OPW'(r_row);
		end else begin
			row_val = (r_row > ROW_MIN) ? OPW'(ROW_MIN) : OPW'(-r_row);
		end
		if (neg_q) begin
			pix_val = '0;
		end else begin
			pix_val = (r_col > PIX_MAX) ? SAMPLE_W'(PIX_MAX) : SAMPLE_W'(r_col);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= E_IDLE;
			col_q       <= 1'b0;
			y_q         <= '0;
			x_q         <= '0;
			k_q         <= '0;
			rd_s1       <= 1'b0;
			mul_s2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_s1  <= issue;
			mul_s2 <= rd_s1;
			if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				E_IDLE: begin
					if (start) begin
						state_q <= E_RUN;
						col_q   <= 1'b0;
						y_q     <= '0;
						x_q     <= '0;
						k_q     <= '0;
					end
				end
				E_RUN: begin
					k_q <= k_q + 3'd1;
					if (k_q == 3'd7) begin
						state_q <= E_DRAIN;
					end
				end
				E_DRAIN: begin
					if (!rd_s1 && !mul_s2) begin
						state_q <= E_FIN;
					end
				end
				E_FIN: state_q <= E_DONE;
				E_DONE: begin
					if (done_go) begin
						if (col_q) begin
							out_valid_q <= 1'b1;
						end
						{y_q, x_q} <= {y_q, x_q} + POS_W'(1);
						k_q        <= '0;
						if (last_elem) begin
							if (col_q) begin
								state_q <= E_IDLE;
							end else begin
								col_q   <= 1'b1;
								state_q <= E_RUN;
							end
						end else begin
							state_q <= E_RUN;
						end
					end
				end
				default: state_q <= E_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			w_s1 <= WW'(weight(col_q ? y_q : x_q, k_q, COS_FRAC_BITS));
		end
		if (rd_s1) begin
			prod_s2 <= PW'(operand) * PW'(w_s1);
		end
		if (state_q == E_IDLE || done_go) begin
			acc_q <= '0;
		end else if (mul_s2) begin
			acc_q <= acc_q + AW'(prod_s2);
		end
		if (state_q == E_FIN) begin
			neg_q <= fin_val[AW-1];
			mag_q <= fin_val[AW-1] ? AW'(-fin_val) : AW'(fin_val);
		end
		if (done_go && col_q) begin
			sample_q <= pix_val;
			index_q  <= {y_q, x_q};
			last_q   <= last_elem;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.sample      = sample_q;
	assign out_ch.pixel_index = index_q;
	assign out_ch.last        = last_q;

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for dequant_idct_8x8. Input words (quantizer loads and
// coefficients) are queued, driven on random idle patterns, and predicted on
// acceptance by a bit-accurate dequantizer and two-pass IDCT model; every
// output sample word is compared against the oldest predicted sample.
// ----------------------------------------------------------------------------
module tb;
	import dqi_pkg::*;

	localparam bit MODE_QUANT = 1'b0;
	localparam bit MODE_COEF  = 1'b1;
	localparam int CFRAC      = COS_FRAC_DEF;
	localparam int HOLD_CYC   = 400;

	typedef struct {
		bit                       mode;
		bit [POS_W-1:0]           position;
		bit signed [IN_COEF_W-1:0] coefficient;
		bit [QUANT_W-1:0]         quant_value;
		bit                       drain;
	} in_word_t;

	typedef struct {
		bit [SAMPLE_W-1:0] sample;
		bit [POS_W-1:0]    pixel_index;
		bit                last;
	} sample_word_t;

	logic clk;
	logic arst_n;
	dqi_in_if  in_ch();
	dqi_out_if out_ch();

	dequant_idct_8x8 i_dut (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch));

	in_word_t     pending_q[$];
	sample_word_t sample_q[$];
	bit [QUANT_W-1:0] qtab[NPOS];
	longint       dq_coef[NPOS];
	longint       row_res[NPOS];
	int           errors;
	int           words_taken;
	int           samples_seen;
	int           hold_cnt;
	bit           hold_done;
	bit           in_taken;

	localparam longint COS_TAB [0:8] = '{16777216, 16454846, 15500126, 13949745,
		11863283, 9320922, 6420363, 3273072, 0};

	function automatic longint cos_w(int i, int u);
		int     k;
		longint m;
		bit     neg;
		k   = ((2 * i + 1) * u) & 31;
		neg = 0;
		if (u == 0) m = COS_TAB[4];
		else if (k <= 8) m = COS_TAB[k];
		else if (k <= 16) begin
			m   = COS_TAB[16 - k];
			neg = 1;
		end else if (k <= 24) begin
			m   = COS_TAB[k - 16];
			neg = 1;
		end else m = COS_TAB[32 - k];
		m = (m + (64'sd1 << (TAB_BITS - CFRAC - 1))) >>> (TAB_BITS - CFRAC);
		return neg ? -m : m;
	endfunction

	function automatic longint round_half_away(longint v, int s);
		longint mag;
		mag = v < 0 ? -v : v;
		mag = (mag + (64'sd1 << (s - 1))) >>> s;
		return v < 0 ? -mag : mag;
	endfunction

	function automatic longint clip_signed(longint v, int bits);
		longint hi;
		hi = (64'sd1 << (bits - 1)) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	task automatic add_word(in_word_t w);
		pending_q = {pending_q, w};
	endtask

	task automatic predict_samples();
		longint       acc;
		sample_word_t s;
		for (int y = 0; y < 8; y++)
			for (int x = 0; x < 8; x++) begin
				acc = 0;
				for (int k = 0; k < 8; k++) acc += dq_coef[y * 8 + k] * cos_w(x, k);
				row_res[y * 8 + x] = clip_signed(round_half_away(acc, CFRAC + 1 - 4), ROW_WIDTH);
			end
		for (int y = 0; y < 8; y++)
			for (int x = 0; x < 8; x++) begin
				acc = 0;
				for (int k = 0; k < 8; k++) acc += row_res[k * 8 + x] * cos_w(y, k);
				acc += 64'sd128 << (CFRAC + 5);
				acc = round_half_away(acc, CFRAC + 5);
				if (acc < 0) acc = 0;
				if (acc > 255) acc = 255;
				s.sample      = acc[7:0];
				s.pixel_index = POS_W'(y * 8 + x);
				s.last        = (y * 8 + x) == NPOS - 1;
				sample_q = {sample_q, s};
			end
		for (int p = 0; p < NPOS; p++) dq_coef[p] = 0;
	endtask

	task automatic dequant_word(in_word_t w);
		if (w.mode == MODE_QUANT) begin
			qtab[w.position] = w.quant_value;
		end else begin
			dq_coef[w.position] = clip_signed(longint'(w.coefficient) *
				longint'(qtab[w.position]), COEF_WIDTH_DEF);
			if (w.position == LAST_POS) predict_samples();
		end
	endtask

	function automatic in_word_t mk_word(bit mode, int pos, int coef, int qv);
		in_word_t w;
		w.mode        = mode;
		w.position    = POS_W'(pos);
		w.coefficient = IN_COEF_W'(coef);
		w.quant_value = QUANT_W'(qv);
		w.drain       = 0;
		return w;
	endfunction

	function automatic int rand_coef();
		if ($urandom_range(99) < 80) return int'($urandom_range(64)) - 32;
		return int'($urandom);
	endfunction

	function automatic int rand_quant();
		int r;
		r = $urandom_range(99);
		if (r < 70) return $urandom_range(16, 1);
		if (r < 90) return $urandom;
		return 0;
	endfunction

	task automatic push_random_block(bit drain_first);
		int       order[63];
		int       j, t;
		in_word_t w;
		for (int p = 0; p < 63; p++) order[p] = p;
		for (int p = 62; p > 0; p--) begin
			j        = $urandom_range(p);
			t        = order[p];
			order[p] = order[j];
			order[j] = t;
		end
		for (int p = 0; p < 6; p++)
			add_word(mk_word(MODE_QUANT, $urandom_range(63), 0, rand_quant()));
		if (drain_first) pending_q[pending_q.size() - 6].drain = 1;
		add_word(mk_word(MODE_QUANT, 63, 0, rand_quant()));
		for (int p = 0; p < 63; p++) begin
			if ($urandom_range(99) < 10)
				add_word(mk_word(MODE_QUANT, $urandom_range(63), 0, rand_quant()));
			if ($urandom_range(99) < 5)
				add_word(mk_word(MODE_COEF, order[p], rand_coef(), 0));
			add_word(mk_word(MODE_COEF, order[p], rand_coef(), 0));
		end
		add_word(mk_word(MODE_COEF, 63, rand_coef(), 0));
	endtask

	task automatic push_directed_block();
		add_word(mk_word(MODE_QUANT, 0, 0, 16'hFFFF));
		add_word(mk_word(MODE_QUANT, 1, 0, 1));
		add_word(mk_word(MODE_QUANT, 2, 0, 16'hFFFF));
		add_word(mk_word(MODE_QUANT, 8, 0, 2));
		add_word(mk_word(MODE_QUANT, 63, 0, 3));
		add_word(mk_word(MODE_QUANT, 63, 0, 16'hFFFF));
		add_word(mk_word(MODE_COEF, 0, -32768, 0));
		add_word(mk_word(MODE_COEF, 1, 32767, 0));
		add_word(mk_word(MODE_COEF, 1, -32768, 0));
		add_word(mk_word(MODE_COEF, 2, 32767, 0));
		for (int p = 3; p < 63; p++)
			add_word(mk_word(MODE_COEF, p, p[0] ? -7 : 9, 0));
		add_word(mk_word(MODE_COEF, 8, 40, 0));
		add_word(mk_word(MODE_COEF, 63, -1, 0));
	endtask

	function automatic int tx_idle_pct();
		if (words_taken < 80) return 29;
		if (words_taken < 160) return 80;
		return 0;
	endfunction

	function automatic int rx_idle_pct();
		if (words_taken < 80) return 80;
		if (words_taken < 160) return 29;
		return 0;
	endfunction

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4ms;
		$display("FAIL");
		$finish;
	end

	// sender
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else if (!in_ch.valid || in_taken) begin
			if (pending_q.size() == 0 || $urandom_range(99) < tx_idle_pct() ||
					(pending_q[0].drain && sample_q.size() != 0)) begin
				in_ch.valid <= 1'b0;
			end else begin
				in_ch.valid       <= 1'b1;
				in_ch.mode        <= pending_q[0].mode;
				in_ch.position    <= pending_q[0].position;
				in_ch.coefficient <= pending_q[0].coefficient;
				in_ch.quant_value <= pending_q[0].quant_value;
				void'(pending_q.pop_front());
			end
		end
	end

	// receiver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (samples_seen == 100 && !hold_done) begin
				hold_done = 1;
				hold_cnt  = HOLD_CYC;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= $urandom_range(99) >= rx_idle_pct();
			end
		end
	end

	// input and output monitor
	always @(posedge clk) begin
		in_word_t     w;
		sample_word_t e;
		in_taken <= in_ch.valid && in_ch.ready;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			w.mode        = in_ch.mode;
			w.position    = in_ch.position;
			w.coefficient = in_ch.coefficient;
			w.quant_value = in_ch.quant_value;
			dequant_word(w);
			words_taken++;
		end
		if (arst_n && out_ch.valid && out_ch.ready) begin
			samples_seen++;
			if (sample_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected word idx %0d sample %0d", $time,
					out_ch.pixel_index, out_ch.sample);
			end else begin
				e = sample_q.pop_front();
				if (out_ch.sample !== e.sample || out_ch.pixel_index !== e.pixel_index ||
						out_ch.last !== e.last) begin
					errors++;
					$display("%0t: mismatch exp s=%0d i=%0d l=%0d got s=%0d i=%0d l=%0d",
						$time, e.sample, e.pixel_index, e.last, out_ch.sample,
						out_ch.pixel_index, out_ch.last);
				end
			end
		end
	end

	initial begin
		arst_n             = 1'b0;
		in_ch.valid        = 1'b0;
		in_ch.mode         = MODE_QUANT;
		in_ch.position     = '0;
		in_ch.coefficient  = '0;
		in_ch.quant_value  = '0;
		out_ch.ready       = 1'b0;
		in_taken           = 0;
		errors             = 0;
		words_taken        = 0;
		samples_seen       = 0;
		hold_cnt           = 0;
		hold_done          = 0;
		for (int p = 0; p < NPOS; p++) begin
			qtab[p]    = '0;
			dq_coef[p] = 0;
		end
		push_directed_block();
		push_random_block(1'b1);
		push_random_block(1'b0);
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (pending_q.size() == 0 && !in_ch.valid);
		wait (sample_q.size() == 0);
		repeat (2000) @(posedge clk);
		if (errors == 0 && sample_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

[sim.f]
hdl/dqi_pkg.sv
hdl/dqi_if.sv
hdl/dqi_ram.sv
hdl/dqi_dequant.sv
hdl/dqi_idct.sv
hdl/dequant_idct_8x8.sv
dv/tb.sv
